/* src/keyed_xor_packet_scrambler_macros.svh */
// Assertion helpers for the scrambler top level.
`ifndef KEYED_XOR_PACKET_SCRAMBLER_MACROS_SVH
`define KEYED_XOR_PACKET_SCRAMBLER_MACROS_SVH

`ifndef SYNTHESIS
`define KXPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KXPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KXPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KXPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/kxps_pkg.sv */
`default_nettype none

package kxps_pkg;

  localparam int KEY_BYTES_DEF   = 128;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int START_BITS      = 7;
  localparam int KEY_IDX_BITS    = 10;
  localparam int ROM_BYTES       = 128;

  localparam logic [7:0] KEY_ROM [ROM_BYTES] = '{
    8'hDC, 8'h47, 8'hE2, 8'hA6, 8'h0D, 8'h70, 8'h71, 8'h21,
    8'h6D, 8'h21, 8'h28, 8'hDD, 8'hD1, 8'h6D, 8'h20, 8'hA4,
    8'hAC, 8'h88, 8'h0A, 8'h75, 8'hD5, 8'h7F, 8'h12, 8'hD4,
    8'h8A, 8'h26, 8'h0A, 8'h65, 8'hB4, 8'h52, 8'hC4, 8'hB9,
    8'h6C, 8'h49, 8'hBF, 8'h68, 8'hBF, 8'h77, 8'h06, 8'h60,
    8'hAE, 8'h63, 8'h56, 8'h7C, 8'h79, 8'hE1, 8'h7F, 8'h59,
    8'h1E, 8'h88, 8'h0C, 8'h65, 8'h1C, 8'h66, 8'h26, 8'h38,
    8'h7C, 8'hF3, 8'hB6, 8'h28, 8'h12, 8'h44, 8'hCA, 8'h17,
    8'h01, 8'h81, 8'h3A, 8'h90, 8'h7D, 8'h99, 8'h8B, 8'h13,
    8'hD5, 8'h34, 8'h13, 8'hAC, 8'hB0, 8'hEA, 8'h5E, 8'hCA,
    8'h96, 8'hB2, 8'hD1, 8'h4F, 8'hB3, 8'h9D, 8'h8D, 8'hE4,
    8'hD8, 8'hC4, 8'h97, 8'h8F, 8'hC3, 8'h7E, 8'h35, 8'h87,
    8'hA0, 8'hD7, 8'h9B, 8'h47, 8'hD0, 8'h3E, 8'hC6, 8'hE1,
    8'hE8, 8'h7E, 8'hA9, 8'h95, 8'hFD, 8'hF0, 8'h87, 8'hA2,
    8'h1F, 8'hEE, 8'hA0, 8'h5C, 8'h23, 8'h8A, 8'h0F, 8'h7F,
    8'hA6, 8'h80, 8'hF3, 8'hC3, 8'h4E, 8'h6A, 8'hCD, 8'hB0
  };

  // Key entries beyond the fixed table read as zero.
  function automatic logic [7:0] key_byte(input logic [KEY_IDX_BITS-1:0] idx);
    logic [7:0] val;
    val = 8'h00;
    if (idx < KEY_IDX_BITS'(ROM_BYTES)) begin
      val = KEY_ROM[idx[6:0]];
    end
    return val;
  endfunction

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_packet;
    logic [15:0] packet_length;
    logic [3:0]  key_offset_index;
    logic [15:0] random_word;
  } kxps_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_packet;
  } kxps_out_t;

  // Work carried from the address stage to the combine stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       key_en;
    logic       last;
  } kxps_req_t;

endpackage

`default_nettype wire

/* src/keyed_xor_packet_scrambler.sv */
// Path: an input byte's request and key read are registered, then its result in out_r.
// Throughput: one byte per cycle while out_ready stays high; the key memory read
// port takes one address a cycle. Reset: synchronous, active low.
// After reset the key memory is loaded from the constant table while in_ready stays low.
`default_nettype none
`include "keyed_xor_packet_scrambler_macros.svh"

module keyed_xor_packet_scrambler #(
  parameter int KEY_BYTES   = kxps_pkg::KEY_BYTES_DEF,
  parameter int LENGTH_BITS = kxps_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire kxps_pkg::kxps_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output kxps_pkg::kxps_out_t       out_data
);

  localparam int PW = $clog2(KEY_BYTES);

  logic [PW:0]   fill_cnt_r, fill_cnt_nxt;
  logic          fill_done;
  logic [PW-1:0] key_addr;
  logic [7:0]    key_rdata;
  logic          in_accept, s1_move;

  kxps_pkg::kxps_req_t req, s1_req_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  kxps_pkg::kxps_out_t out_r;

  assign fill_done    = fill_cnt_r == (PW+1)'(KEY_BYTES);
  assign fill_cnt_nxt = fill_cnt_r + (PW+1)'(1);

  kxps_ram #(
    .WIDTH (8),
    .DEPTH (KEY_BYTES)
  ) u_key_ram (
    .clk   (clk),
    .we    (!fill_done),
    .waddr (fill_cnt_r[PW-1:0]),
    .wdata (kxps_pkg::key_byte(kxps_pkg::KEY_IDX_BITS'(fill_cnt_r[PW-1:0]))),
    .re    (in_accept),
    .raddr (key_addr),
    .rdata (key_rdata)
  );

  kxps_ctrl #(
    .KEY_BYTES   (KEY_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_accept),
    .in_item  (in_data),
    .key_addr (key_addr),
    .req      (req)
  );

  // The read data stays on the memory output until the next accepted byte,
  // so a stalled combine stage simply holds.
  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = fill_done && (!s1_valid_r || s1_move);
  assign in_accept = in_valid && in_ready;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!fill_done) begin
        fill_cnt_r <= fill_cnt_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= req;
    end
    if (s1_move) begin
      out_r.out_byte       <= s1_req_r.data ^ s1_req_r.mask ^
                              (s1_req_r.key_en ? key_rdata : 8'h00);
      out_r.last_of_packet <= s1_req_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `KXPS_ASSERT_SAME(a_no_work_before_load, clk, rst_n, s1_valid_r, fill_done)
  `KXPS_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_r && out_valid_r && !out_ready,
                    s1_valid_r)
  `KXPS_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid_r && !out_ready,
                    out_valid_r && $stable(out_r))

endmodule

`default_nettype wire

/* src/kxps_ram.sv */
`default_nettype none

module kxps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/kxps_ctrl.sv */
`default_nettype none

module kxps_ctrl #(
  parameter int KEY_BYTES   = kxps_pkg::KEY_BYTES_DEF,
  parameter int LENGTH_BITS = kxps_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire kxps_pkg::kxps_in_t           in_item,
  output logic      [$clog2(KEY_BYTES)-1:0] key_addr,
  output kxps_pkg::kxps_req_t               req
);

  localparam int PW  = $clog2(KEY_BYTES);
  localparam int SB  = kxps_pkg::START_BITS;
  localparam int LB  = LENGTH_BITS;
  localparam int MX1 = (LB > PW) ? LB : PW;
  localparam int BW  = ((MX1 > SB) ? MX1 : SB) + 1;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [LB-1:0] count_r, count_nxt;
  logic [LB-1:0] len_r, len_nxt;
  logic [SB-1:0] start_r, start_nxt;
  logic [15:0]   rnd_r, rnd_nxt;

  logic [PW-1:0] eff_pos, tail_pos, pos_adv;
  logic [PW:0]   pos_plus;
  logic [LB-1:0] eff_cnt, slen;
  logic [BW-1:0] base;
  logic [1:0]    lane;
  logic          active, in_word;

  always_comb begin
    len_nxt   = len_r;
    start_nxt = start_r;
    rnd_nxt   = rnd_r;
    eff_cnt   = count_r;
    eff_pos   = pos_r;
    if (in_item.first_of_packet) begin
      len_nxt   = LB'(in_item.packet_length);
      start_nxt = {in_item.key_offset_index, 3'b000};
      rnd_nxt   = in_item.random_word;
      eff_cnt   = '0;
      if (32'(start_nxt) >= 32'(KEY_BYTES - 4)) begin
        eff_pos = '0;
      end else begin
        eff_pos = PW'(start_nxt);
      end
    end

    active  = eff_cnt < len_nxt;
    slen    = len_nxt & ~LB'(3);
    in_word = eff_cnt < slen;
    lane    = eff_cnt[1:0];

    // The tail restarts the key walk right after the word part.
    base = BW'(start_nxt) + BW'(slen);
    tail_pos = eff_pos;
    if (eff_cnt == slen) begin
      tail_pos = (base < BW'(KEY_BYTES)) ? PW'(base) : '0;
    end

    if (in_word) begin
      key_addr = eff_pos + PW'(lane);
      pos_plus = (PW+1)'(eff_pos) + (PW+1)'(4);
      if (lane == 2'd3) begin
        pos_adv = (pos_plus >= (PW+1)'(KEY_BYTES - 4)) ? '0 : PW'(pos_plus);
      end else begin
        pos_adv = eff_pos;
      end
    end else begin
      key_addr = tail_pos;
      pos_plus = (PW+1)'(tail_pos) + (PW+1)'(1);
      pos_adv  = (pos_plus >= (PW+1)'(KEY_BYTES)) ? '0 : PW'(pos_plus);
    end

    count_nxt = active ? eff_cnt + LB'(1) : eff_cnt;
    pos_nxt   = active ? pos_adv : eff_pos;

    req.data   = in_item.data_byte;
    req.key_en = active;
    req.last   = active && (eff_cnt + LB'(1) == len_nxt);
    req.mask   = 8'h00;
    if (active && in_word) begin
      req.mask = lane[0] ? rnd_nxt[15:8] : rnd_nxt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      len_r   <= '0;
      start_r <= '0;
      rnd_r   <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule

`default_nettype wire
